/* sv/lcdr_pkg.sv */
`default_nettype none

package lcdr_pkg;

   // Geometry and field widths
   localparam int LINE_LENGTH_DEFAULT = 20;
   localparam int LINE_COUNT          = 4;
   localparam int STEP_W              = 6;
   localparam int UPC_W               = 4;
   localparam int CSR_INDEX_W         = 2;

   // Input operations
   localparam logic [1:0] OP_TICK      = 2'd0;
   localparam logic [1:0] OP_BUS_DONE  = 2'd1;
   localparam logic [1:0] OP_WRITE     = 2'd2;
   localparam logic [1:0] OP_INIT      = 2'd3;

   // Bus actions
   localparam logic [2:0] ACT_START    = 3'd0;
   localparam logic [2:0] ACT_RSTART   = 3'd1;
   localparam logic [2:0] ACT_SEND     = 3'd2;
   localparam logic [2:0] ACT_STOP     = 3'd3;
   localparam logic [2:0] ACT_WAIT     = 3'd4;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SLAVE_ADDR  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REFRESH_DIV = 2'd1;
   localparam logic [7:0] SLAVE_ADDR_RESET  = 8'h78;
   localparam logic [7:0] REFRESH_DIV_RESET = 8'd5;

   // Bus status codes that count as success
   localparam logic [7:0] STATUS_MASK     = 8'hF8;
   localparam logic [7:0] TWI_START_SENT  = 8'h08;
   localparam logic [7:0] TWI_RSTART_SENT = 8'h10;
   localparam logic [7:0] TWI_SLA_ACK     = 8'h18;
   localparam logic [7:0] TWI_DATA_ACK    = 8'h28;

   // LCD bytes
   localparam logic [7:0] SPACE_CHAR    = 8'h20;
   localparam logic [7:0] BYTE_CTRL_CMD = 8'h80;
   localparam logic [7:0] BYTE_DDRAM_L2 = 8'hC0;
   localparam logic [7:0] BYTE_CTRL_DAT = 8'h40;
   localparam logic [7:0] BYTE_FUNC_SET = 8'h38;
   localparam logic [7:0] BYTE_DISP_ON  = 8'h0C;
   localparam logic [7:0] BYTE_CLEAR    = 8'h01;

   // Delays in 100 us units
   localparam logic [8:0] WAIT_POWER_UP = 9'd400;
   localparam logic [8:0] WAIT_CLEAR    = 9'd100;
   localparam logic [8:0] WAIT_SHORT    = 9'd1;

   // Sequence steps
   localparam logic [STEP_W-1:0] STEP_IDLE      = 6'd0;
   localparam logic [STEP_W-1:0] STEP_REFRESH   = 6'd1;
   localparam logic [STEP_W-1:0] STEP_INIT_ADDR = 6'd18;

   // Byte source for a send
   localparam logic [1:0] BSEL_NONE  = 2'd0;
   localparam logic [1:0] BSEL_ADDR  = 2'd1;
   localparam logic [1:0] BSEL_CONST = 2'd2;
   localparam logic [1:0] BSEL_LINE  = 2'd3;

   // Entry points of the result micro-program
   localparam logic [UPC_W-1:0] UPC_START      = 4'd0;
   localparam logic [UPC_W-1:0] UPC_INIT       = 4'd1;
   localparam logic [UPC_W-1:0] UPC_SEND       = 4'd3;
   localparam logic [UPC_W-1:0] UPC_RSTART     = 4'd4;
   localparam logic [UPC_W-1:0] UPC_STOP       = 4'd5;
   localparam logic [UPC_W-1:0] UPC_STOP_WS    = 4'd6;
   localparam logic [UPC_W-1:0] UPC_STOP_WL    = 4'd9;
   localparam logic [UPC_W-1:0] UPC_STOP_WAIT  = 4'd12;

   // Control word of one sequence step
   typedef struct packed {
      logic              emit;
      logic [UPC_W-1:0]  entry;
      logic [1:0]        byte_sel;
      logic [7:0]        const_byte;
      logic [1:0]        line;
      logic              clr_pos;
      logic [STEP_W-1:0] next_step;
   } lcdr_ctrl_type;

   // One result micro-instruction
   typedef struct packed {
      logic [2:0] action;
      logic [8:0] wait_units;
      logic       last;
   } lcdr_uop_type;

   // Step program: what a successful bus event does in each step
   function automatic lcdr_ctrl_type step_rom(input logic [STEP_W-1:0] s);
      lcdr_ctrl_type c;
      c           = '0;
      c.next_step = s + 1'b1;
      unique case (s) inside
         6'd1, 6'd8, 6'd18, 6'd22, 6'd26, 6'd30: begin
            c.emit = 1'b1; c.entry = UPC_SEND; c.byte_sel = BSEL_ADDR;
         end
         6'd2, 6'd3, 6'd9, 6'd19, 6'd23, 6'd27, 6'd31: begin
            c.emit = 1'b1; c.entry = UPC_SEND; c.byte_sel = BSEL_CONST;
            c.const_byte = BYTE_CTRL_CMD;
         end
         6'd4: begin
            c.emit = 1'b1; c.entry = UPC_SEND; c.byte_sel = BSEL_CONST;
            c.const_byte = BYTE_CTRL_DAT;
         end
         6'd11: begin
            c.emit = 1'b1; c.entry = UPC_SEND; c.byte_sel = BSEL_CONST;
            c.const_byte = BYTE_CTRL_DAT; c.clr_pos = 1'b1;
         end
         6'd10: begin
            c.emit = 1'b1; c.entry = UPC_SEND; c.byte_sel = BSEL_CONST;
            c.const_byte = BYTE_DDRAM_L2;
         end
         6'd20: begin
            c.emit = 1'b1; c.entry = UPC_SEND; c.byte_sel = BSEL_CONST;
            c.const_byte = BYTE_FUNC_SET;
         end
         6'd24: begin
            c.emit = 1'b1; c.entry = UPC_SEND; c.byte_sel = BSEL_CONST;
            c.const_byte = BYTE_DISP_ON;
         end
         6'd28, 6'd32: begin
            c.emit = 1'b1; c.entry = UPC_SEND; c.byte_sel = BSEL_CONST;
            c.const_byte = BYTE_CLEAR;
         end
         // line 1, line 3, line 2, line 4
         6'd5: begin
            c.emit = 1'b1; c.entry = UPC_SEND; c.byte_sel = BSEL_LINE; c.line = 2'd0;
         end
         6'd6: begin
            c.emit = 1'b1; c.entry = UPC_SEND; c.byte_sel = BSEL_LINE; c.line = 2'd2;
         end
         6'd12: begin
            c.emit = 1'b1; c.entry = UPC_SEND; c.byte_sel = BSEL_LINE; c.line = 2'd1;
         end
         6'd13: begin
            c.emit = 1'b1; c.entry = UPC_SEND; c.byte_sel = BSEL_LINE; c.line = 2'd3;
         end
         6'd7: begin
            c.emit = 1'b1; c.entry = UPC_RSTART;
         end
         6'd14: begin
            c.emit = 1'b1; c.entry = UPC_STOP; c.next_step = STEP_IDLE;
         end
         6'd21, 6'd25: begin
            c.emit = 1'b1; c.entry = UPC_STOP_WS;
         end
         6'd29: begin
            c.emit = 1'b1; c.entry = UPC_STOP_WL;
         end
         6'd33: begin
            c.emit = 1'b1; c.entry = UPC_STOP_WAIT; c.next_step = STEP_IDLE;
         end
         // idle and unused steps: back to idle, nothing sent
         default: begin
            c.next_step = STEP_IDLE;
         end
      endcase
      return c;
   endfunction

   // Result micro-program; last marks the end of a sequence
   function automatic lcdr_uop_type uop_rom(input logic [UPC_W-1:0] a);
      lcdr_uop_type u;
      u = '0;
      unique case (a)
         4'd0:    begin u.action = ACT_START;  u.last = 1'b1; end
         4'd1:    begin u.action = ACT_WAIT;   u.wait_units = WAIT_POWER_UP; end
         4'd2:    begin u.action = ACT_START;  u.last = 1'b1; end
         4'd3:    begin u.action = ACT_SEND;   u.last = 1'b1; end
         4'd4:    begin u.action = ACT_RSTART; u.last = 1'b1; end
         4'd5:    begin u.action = ACT_STOP;   u.last = 1'b1; end
         4'd6:    begin u.action = ACT_STOP; end
         4'd7:    begin u.action = ACT_WAIT;   u.wait_units = WAIT_SHORT; end
         4'd8:    begin u.action = ACT_START;  u.last = 1'b1; end
         4'd9:    begin u.action = ACT_STOP; end
         4'd10:   begin u.action = ACT_WAIT;   u.wait_units = WAIT_CLEAR; end
         4'd11:   begin u.action = ACT_START;  u.last = 1'b1; end
         4'd12:   begin u.action = ACT_STOP; end
         4'd13:   begin u.action = ACT_WAIT;   u.wait_units = WAIT_SHORT; u.last = 1'b1; end
         default: begin u.action = ACT_STOP;   u.last = 1'b1; end
      endcase
      return u;
   endfunction

endpackage

`default_nettype wire

/* sv/lcdr_line_store.sv */
`default_nettype none

module lcdr_line_store
   import lcdr_pkg::*;
#(
   parameter int LINE_LENGTH = LINE_LENGTH_DEFAULT,
   parameter int ADDR_W      = $clog2(LINE_COUNT * LINE_LENGTH)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [7:0]        rd_data
);

   localparam int DEPTH = LINE_COUNT * LINE_LENGTH;

   logic [7:0]       mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [7:0]       rd_data_ff;
   logic             rd_valid_ff;

   // Character array, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Entries not yet written read as spaces
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : SPACE_CHAR;

endmodule

`default_nettype wire

/* sv/i2c_lcd_refresh_sequencer.sv */
// With rsp_ready held high, an item that causes results is accepted, passes through the
// load state (registered line-store read and output load), then gives one result per
// cycle from the micro-program; a write or silent item leaves the sequencer idle.
// One item at a time: no new item is accepted until the final result of the last one is taken.
// Reset (synchronous): sequencer idle, counters cleared, registers to defaults,
// line store reads as spaces at once through per-entry valid bits.
`default_nettype none

module i2c_lcd_refresh_sequencer
   import lcdr_pkg::*;
#(
   parameter int LINE_LENGTH = LINE_LENGTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // requests
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [1:0]             req_op,
   input  wire logic [7:0]             req_bus_status,
   input  wire logic [1:0]             req_line_number,
   input  wire logic [4:0]             req_column,
   input  wire logic [7:0]             req_char_code,
   // results
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [2:0]                  rsp_action,
   output logic [7:0]                  rsp_byte_out,
   output logic [8:0]                  rsp_wait_units,
   output logic                        rsp_last,
   // registers
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]             csr_wdata
);

   localparam int ADDR_W = $clog2(LINE_COUNT * LINE_LENGTH);
   localparam int POS_W  = $clog2(LINE_LENGTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [7:0]        tick_ff, tick_in;
   logic [7:0]        slave_addr_ff, refresh_div_ff;
   logic [UPC_W-1:0]  upc_ff, upc_in;
   logic [1:0]        bsel_ff, bsel_in;
   logic [7:0]        const_ff, const_in;
   logic [7:0]        byte_ff;
   logic [2:0]        action_ff;
   logic [7:0]        byte_out_ff;
   logic [8:0]        wait_ff;
   logic              last_ff;

   lcdr_ctrl_type     ctrl;
   lcdr_uop_type      uop;
   logic [UPC_W-1:0]  upc_look;
   logic              req_fire, rsp_fire, status_ok, pos_end, col_ok, load_out;
   logic [7:0]        status_m, tick_inc, sel_byte, shown_byte;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]        rd_data;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   // Step decode and status check
   assign ctrl      = step_rom(step_ff);
   assign status_m  = req_bus_status & STATUS_MASK;
   assign status_ok = (status_m == TWI_START_SENT) || (status_m == TWI_RSTART_SENT)
                   || (status_m == TWI_SLA_ACK) || (status_m == TWI_DATA_ACK);
   assign pos_end   = (pos_ff == POS_W'(LINE_LENGTH - 1));
   assign tick_inc  = tick_ff + 8'd1;
   assign col_ok    = (32'(req_column) < LINE_LENGTH);

   // Line store ports
   assign wr_en   = req_fire && (req_op == OP_WRITE) && col_ok;
   assign wr_addr = ADDR_W'(req_line_number) * ADDR_W'(LINE_LENGTH) + ADDR_W'(req_column);
   assign rd_addr = ADDR_W'(ctrl.line) * ADDR_W'(LINE_LENGTH) + ADDR_W'(pos_ff);

   lcdr_line_store #(
      .LINE_LENGTH (LINE_LENGTH),
      .ADDR_W      (ADDR_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_char_code),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer: accepted item updates step, position and tick count and may start a result sequence
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      pos_in   = pos_ff;
      tick_in  = tick_ff;
      upc_in   = upc_ff;
      bsel_in  = bsel_ff;
      const_in = const_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_op)
                  OP_TICK: begin
                     tick_in = tick_inc;
                     if (tick_inc >= refresh_div_ff) begin
                        tick_in = 8'd0;
                        if (step_ff == STEP_IDLE) begin
                           step_in  = STEP_REFRESH;
                           pos_in   = '0;
                           upc_in   = UPC_START;
                           bsel_in  = BSEL_NONE;
                           state_in = ST_LOAD;
                        end
                     end
                  end
                  OP_BUS_DONE: begin
                     if (status_ok) begin
                        step_in = ctrl.next_step;
                        if (ctrl.clr_pos) begin
                           pos_in = '0;
                        end
                        // walk along a line; leave the step at its end
                        if (ctrl.byte_sel == BSEL_LINE) begin
                           if (pos_end) begin
                              pos_in = '0;
                           end else begin
                              pos_in  = pos_ff + 1'b1;
                              step_in = step_ff;
                           end
                        end
                        if (ctrl.emit) begin
                           upc_in   = ctrl.entry;
                           bsel_in  = ctrl.byte_sel;
                           const_in = ctrl.const_byte;
                           state_in = ST_LOAD;
                        end
                     end
                  end
                  OP_WRITE: begin
                  end
                  OP_INIT: begin
                     step_in  = STEP_INIT_ADDR;
                     pos_in   = '0;
                     upc_in   = UPC_INIT;
                     bsel_in  = BSEL_NONE;
                     state_in = ST_LOAD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LOAD: begin
            state_in = ST_EMIT;
            upc_in   = upc_look;
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  upc_in = upc_look;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Byte for a send and the next micro-instruction
   always_comb begin
      case (bsel_ff)
         BSEL_ADDR:  sel_byte = slave_addr_ff;
         BSEL_CONST: sel_byte = const_ff;
         BSEL_LINE:  sel_byte = rd_data;
         default:    sel_byte = 8'd0;
      endcase
   end

   assign shown_byte = (state_ff == ST_LOAD) ? sel_byte : byte_ff;
   assign upc_look   = (state_ff == ST_LOAD) ? upc_ff : upc_ff + 1'b1;
   assign uop        = uop_rom(upc_look);
   assign load_out   = (state_ff == ST_LOAD) || (rsp_fire && !last_ff);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         step_ff        <= STEP_IDLE;
         pos_ff         <= '0;
         tick_ff        <= 8'd0;
         upc_ff         <= '0;
         slave_addr_ff  <= SLAVE_ADDR_RESET;
         refresh_div_ff <= REFRESH_DIV_RESET;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         pos_ff   <= pos_in;
         tick_ff  <= tick_in;
         upc_ff   <= upc_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SLAVE_ADDR:  slave_addr_ff  <= csr_wdata;
               CSR_REFRESH_DIV: refresh_div_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Payload and output registers
   always_ff @(posedge clock) begin
      bsel_ff  <= bsel_in;
      const_ff <= const_in;
      if (state_ff == ST_LOAD) begin
         byte_ff <= sel_byte;
      end
      if (load_out) begin
         action_ff   <= uop.action;
         byte_out_ff <= (uop.action == ACT_SEND) ? shown_byte : 8'd0;
         wait_ff     <= uop.wait_units;
      end
   end

   // last is read by the sequencer, so it is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= 1'b0;
      end else if (load_out) begin
         last_ff <= uop.last;
      end
   end

   assign rsp_action     = action_ff;
   assign rsp_byte_out   = byte_out_ff;
   assign rsp_wait_units = wait_ff;
   assign rsp_last       = last_ff;

`ifndef SYNTHESIS
   // never take a request while a result is pending
   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("request accepted while result pending");
   // line position stays inside a line
   assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) < LINE_LENGTH)
      else $error("line position out of range");
   // the final result of a sequence frees the input side
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> req_ready)
      else $error("not ready after final result");
   // init always enters the init sequence
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_op == OP_INIT)) |=> (step_ff == STEP_INIT_ADDR))
      else $error("init did not enter init sequence");
`endif

endmodule

`default_nettype wire
